>>> hw/rtl/hnps_pkg.sv
// ----------------------------------------------------------------------------
// hnps_pkg
// Shared types, constants and helpers of the node placement selector.
// ----------------------------------------------------------------------------
package hnps_pkg;

  localparam int NODES   = 64;
  localparam int IDX_W   = $clog2(NODES);
  localparam int CNT_W   = $clog2(NODES + 1);
  localparam int ID_W    = 16;
  localparam int UTIL_W  = 17;
  localparam int KABS_W  = 7;
  localparam int DRAW_W  = 16;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 17;
  localparam int KEY_W   = UTIL_W + ID_W + IDX_W;

  localparam logic [CIDX_W-1:0] REG_SPREAD_THR = 3'd0;
  localparam logic [CIDX_W-1:0] REG_TOPK_ABS   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_TOPK_FRAC  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_AVOID_GPU  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_AVOID_LOC  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_REQ_AVAIL  = 3'd5;

  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic              alive;
    logic              has_gpu;
    logic              feasible;
    logic              available;
    logic              available_loose;
    logic [UTIL_W-1:0] util;
  } rec_t;

  typedef struct packed {
    rec_t             rec;
    logic [IDX_W-1:0] lidx;
    logic             in_a;
    logic             in_u;
    logic             is_pref;
    logic             member;
    logic [IDX_W-1:0] rank;
  } ent_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_PREP,
    CELL_SEL,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic              non_gpu;
    logic              avoid_local;
    logic              has_pref;
    logic [IDX_W-1:0]  pref_idx;
    logic              sel_u;
    logic [UTIL_W-1:0] thr;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SEL,
    ST_ROT,
    ST_EVAL,
    ST_MOD,
    ST_PICK,
    ST_DONE
  } state_t;

  function automatic logic [UTIL_W-1:0] score_of(input logic [UTIL_W-1:0] u,
                                                 input logic [UTIL_W-1:0] thr);
    score_of = (u < thr) ? '0 : u;
  endfunction

  function automatic logic [KEY_W-1:0] key_of(input ent_t e, input logic [UTIL_W-1:0] thr);
    key_of = {score_of(e.rec.util, thr), e.rec.ident, e.lidx};
  endfunction

endpackage

>>> hw/rtl/hybrid_node_placement_selector.sv
// ----------------------------------------------------------------------------
// hybrid_node_placement_selector
// Loads node records into a chain of cells and, on the last record, picks a
// node by score rank, preferred node and random draw.
// ----------------------------------------------------------------------------
//  channel | direction | beat
//  in_     | in        | one node record, last marks the end of a set
//  out_    | out       | found flag and chosen node, one per last record
//  cfg_    | in        | register index and write data
//
// Records load one per cycle while idle. After the last record a decision runs
// prepare, select, a rotation of the cell chain for ranking, evaluate, a bitwise
// remainder over the draw, a pick and the hand-off to the output register. A
// preferred-node win skips the remainder and pick, a no-candidate set skips to
// the hand-off; an empty non-GPU pass under GPU avoidance restarts at prepare.
// Reset (synchronous, rst_n low) empties the table and restores registers.
// A stalled result holds the block in its final step; loading resumes after.
module hybrid_node_placement_selector (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hnps_pkg::ID_W-1:0]   in_node_ident,
  input  logic                        in_alive,
  input  logic                        in_has_gpu,
  input  logic                        in_feasible,
  input  logic                        in_available,
  input  logic                        in_available_loose,
  input  logic [hnps_pkg::UTIL_W-1:0] in_utilization,
  input  logic                        in_is_local,
  input  logic                        in_is_named_preferred,
  input  logic                        in_request_needs_gpu,
  input  logic [hnps_pkg::DRAW_W-1:0] in_random_draw,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [hnps_pkg::ID_W-1:0]   out_chosen_node,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hnps_pkg::CIDX_W-1:0] cfg_index,
  input  logic [hnps_pkg::CDAT_W-1:0] cfg_data
);

  localparam int N    = hnps_pkg::NODES;
  localparam int IW   = hnps_pkg::IDX_W;
  localparam int CW   = hnps_pkg::CNT_W;
  localparam int UW   = hnps_pkg::UTIL_W;
  localparam int IDW  = hnps_pkg::ID_W;
  localparam int DW   = hnps_pkg::DRAW_W;
  localparam int BW   = $clog2(DW);
  localparam int PW   = CW + UW;

  hnps_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                named_v_r, named_v_nxt, local_v_r, local_v_nxt;
  logic [IW-1:0]       named_idx_r, named_idx_nxt, local_idx_r, local_idx_nxt;
  logic                pass_r, pass_nxt;
  logic [DW-1:0]       draw_r, draw_nxt;
  logic [IW-1:0]       rot_r, rot_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [UW-1:0]       min_r, min_nxt;
  logic                pv_r, pv_nxt;
  logic [UW-1:0]       pscore_r, pscore_nxt;
  logic [IDW-1:0]      pid_r, pid_nxt;
  logic [CW-1:0]       m_r, m_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;
  logic [BW-1:0]       bit_r, bit_nxt;
  logic                res_found_r, res_found_nxt;
  logic [IDW-1:0]      res_id_r, res_id_nxt;
  logic [UW-1:0]       thr_r, thr_nxt;
  logic [hnps_pkg::KABS_W-1:0] kabs_r, kabs_nxt;
  logic [UW-1:0]       kfrac_r, kfrac_nxt;
  logic                agpu_r, agpu_nxt, aloc_r, aloc_nxt, reqav_r, reqav_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [IDW-1:0]      out_id_r, out_id_nxt;

  hnps_pkg::cell_ctl_t ctl;
  hnps_pkg::ent_t      ents   [N];
  hnps_pkg::ent_t      prevs  [N];
  hnps_pkg::ent_t      new_ent;
  hnps_pkg::ent_t      head;
  logic [N-1:0]        any_a_vec, any_u_vec, match_vec;
  logic [IDW-1:0]      pick_id;
  logic                in_acc;
  logic                need_av;
  logic [UW-1:0]       head_score;
  logic [PW-1:0]       prod;
  logic [7:0]          kf, kk, mm;
  logic [CW:0]         rem_sh;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == hnps_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign head      = ents[N-1];

  always_comb begin
    new_ent                     = '0;
    new_ent.rec.ident           = in_node_ident;
    new_ent.rec.alive           = in_alive;
    new_ent.rec.has_gpu         = in_has_gpu;
    new_ent.rec.feasible        = in_feasible;
    new_ent.rec.available       = in_available;
    new_ent.rec.available_loose = in_available_loose;
    new_ent.rec.util            = in_utilization;
    new_ent.lidx                = cnt_r[IW-1:0];
  end

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign prevs[gi] = (ctl.op == hnps_pkg::CELL_LOAD) ? new_ent : ents[N-1];
      end else begin : g_rest
        assign prevs[gi] = ents[gi-1];
      end
      hnps_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .pos_valid (CW'(gi) < cnt_r),
        .prev      (prevs[gi]),
        .head      (head),
        .ent       (ents[gi])
      );
      assign any_a_vec[gi] = ents[gi].in_a;
      assign any_u_vec[gi] = ents[gi].in_u;
      assign match_vec[gi] = ents[gi].member && (ents[gi].rank == rem_r[IW-1:0]);
    end
  endgenerate

  always_comb begin
    pick_id = '0;
    for (int i = 0; i < N; i++) begin
      pick_id = pick_id | (match_vec[i] ? ents[i].rec.ident : '0);
    end
  end

  always_comb begin
    head_score = hnps_pkg::score_of(head.rec.util, thr_r);
    need_av    = pass_r || reqav_r;
    prod       = PW'(cnt_r) * PW'(kfrac_r);
    kf         = 8'(prod >> 16);
    kk         = (kf < 8'(kabs_r)) ? 8'(kabs_r) : kf;
    mm         = (kk < 8'(n_r)) ? kk : 8'(n_r);
    if (mm == 8'd0) begin
      mm = 8'd1;
    end
    rem_sh     = {rem_r, draw_r[bit_r]};
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    named_v_nxt   = named_v_r;
    named_idx_nxt = named_idx_r;
    local_v_nxt   = local_v_r;
    local_idx_nxt = local_idx_r;
    pass_nxt      = pass_r;
    draw_nxt      = draw_r;
    rot_nxt       = rot_r;
    n_nxt         = n_r;
    min_nxt       = min_r;
    pv_nxt        = pv_r;
    pscore_nxt    = pscore_r;
    pid_nxt       = pid_r;
    m_nxt         = m_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    res_found_nxt = res_found_r;
    res_id_nxt    = res_id_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_id_nxt    = out_id_r;

    ctl             = '0;
    ctl.op          = hnps_pkg::CELL_HOLD;
    ctl.non_gpu     = pass_r;
    ctl.avoid_local = aloc_r;
    ctl.has_pref    = named_v_r || local_v_r;
    ctl.pref_idx    = named_v_r ? named_idx_r : local_idx_r;
    ctl.thr         = thr_r;

    unique case (state_r)
      hnps_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (cnt_r < CW'(N)) begin
            ctl.op  = hnps_pkg::CELL_LOAD;
            cnt_nxt = cnt_r + 1'b1;
            if (in_is_named_preferred && !named_v_r) begin
              named_v_nxt   = 1'b1;
              named_idx_nxt = cnt_r[IW-1:0];
            end
            if (in_is_local && !local_v_r) begin
              local_v_nxt   = 1'b1;
              local_idx_nxt = cnt_r[IW-1:0];
            end
          end
          if (in_last) begin
            draw_nxt  = in_random_draw;
            pass_nxt  = agpu_r && !in_request_needs_gpu;
            state_nxt = hnps_pkg::ST_PREP;
          end
        end
      end
      hnps_pkg::ST_PREP: begin
        ctl.op    = hnps_pkg::CELL_PREP;
        state_nxt = hnps_pkg::ST_SEL;
      end
      hnps_pkg::ST_SEL: begin
        rot_nxt = '0;
        n_nxt   = '0;
        min_nxt = '1;
        pv_nxt  = 1'b0;
        if (|any_a_vec) begin
          ctl.op    = hnps_pkg::CELL_SEL;
          ctl.sel_u = 1'b0;
          state_nxt = hnps_pkg::ST_ROT;
        end else if ((|any_u_vec) && !need_av) begin
          ctl.op    = hnps_pkg::CELL_SEL;
          ctl.sel_u = 1'b1;
          state_nxt = hnps_pkg::ST_ROT;
        end else if (pass_r) begin
          // The non-GPU pass found nothing; run the general pass.
          pass_nxt  = 1'b0;
          state_nxt = hnps_pkg::ST_PREP;
        end else begin
          res_found_nxt = 1'b0;
          res_id_nxt    = '0;
          state_nxt     = hnps_pkg::ST_DONE;
        end
      end
      hnps_pkg::ST_ROT: begin
        ctl.op  = hnps_pkg::CELL_ROT;
        rot_nxt = rot_r + 1'b1;
        if (head.member) begin
          n_nxt = n_r + 1'b1;
          if (head_score < min_r) begin
            min_nxt = head_score;
          end
          if (head.is_pref) begin
            pv_nxt     = 1'b1;
            pscore_nxt = head_score;
            pid_nxt    = head.rec.ident;
          end
        end
        if (rot_r == IW'(N - 1)) begin
          state_nxt = hnps_pkg::ST_EVAL;
        end
      end
      hnps_pkg::ST_EVAL: begin
        if (!aloc_r && pv_r && (pscore_r <= min_r)) begin
          res_found_nxt = 1'b1;
          res_id_nxt    = pid_r;
          state_nxt     = hnps_pkg::ST_DONE;
        end else begin
          m_nxt     = CW'(mm);
          rem_nxt   = '0;
          bit_nxt   = BW'(DW - 1);
          state_nxt = hnps_pkg::ST_MOD;
        end
      end
      hnps_pkg::ST_MOD: begin
        // Restoring remainder, one draw bit per cycle.
        if (rem_sh >= {1'b0, m_r}) begin
          rem_nxt = CW'(rem_sh - {1'b0, m_r});
        end else begin
          rem_nxt = CW'(rem_sh);
        end
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          state_nxt = hnps_pkg::ST_PICK;
        end
      end
      hnps_pkg::ST_PICK: begin
        res_found_nxt = 1'b1;
        res_id_nxt    = pick_id;
        state_nxt     = hnps_pkg::ST_DONE;
      end
      hnps_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_id_nxt    = res_id_r;
          cnt_nxt       = '0;
          named_v_nxt   = 1'b0;
          local_v_nxt   = 1'b0;
          state_nxt     = hnps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hnps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    thr_nxt   = thr_r;
    kabs_nxt  = kabs_r;
    kfrac_nxt = kfrac_r;
    agpu_nxt  = agpu_r;
    aloc_nxt  = aloc_r;
    reqav_nxt = reqav_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hnps_pkg::REG_SPREAD_THR: thr_nxt   = cfg_data;
        hnps_pkg::REG_TOPK_ABS:   kabs_nxt  = cfg_data[hnps_pkg::KABS_W-1:0];
        hnps_pkg::REG_TOPK_FRAC:  kfrac_nxt = cfg_data;
        hnps_pkg::REG_AVOID_GPU:  agpu_nxt  = cfg_data[0];
        hnps_pkg::REG_AVOID_LOC:  aloc_nxt  = cfg_data[0];
        hnps_pkg::REG_REQ_AVAIL:  reqav_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hnps_pkg::ST_IDLE;
      cnt_r       <= '0;
      named_v_r   <= 1'b0;
      local_v_r   <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= UW'(32768);
      kabs_r      <= hnps_pkg::KABS_W'(1);
      kfrac_r     <= UW'(13107);
      agpu_r      <= 1'b0;
      aloc_r      <= 1'b0;
      reqav_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      named_v_r   <= named_v_nxt;
      local_v_r   <= local_v_nxt;
      out_valid_r <= out_valid_nxt;
      thr_r       <= thr_nxt;
      kabs_r      <= kabs_nxt;
      kfrac_r     <= kfrac_nxt;
      agpu_r      <= agpu_nxt;
      aloc_r      <= aloc_nxt;
      reqav_r     <= reqav_nxt;
    end
  end

  always_ff @(posedge clk) begin
    named_idx_r <= named_idx_nxt;
    local_idx_r <= local_idx_nxt;
    pass_r      <= pass_nxt;
    draw_r      <= draw_nxt;
    rot_r       <= rot_nxt;
    n_r         <= n_nxt;
    min_r       <= min_nxt;
    pv_r        <= pv_nxt;
    pscore_r    <= pscore_nxt;
    pid_r       <= pid_nxt;
    m_r         <= m_nxt;
    rem_r       <= rem_nxt;
    bit_r       <= bit_nxt;
    res_found_r <= res_found_nxt;
    res_id_r    <= res_id_nxt;
    out_found_r <= out_found_nxt;
    out_id_r    <= out_id_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_chosen_node = out_id_r;

`ifndef SYNTH
  a_nil_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_chosen_node == '0)
    else $error("nil result carries a nonzero node");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(N))
    else $error("node count beyond table size");
  a_pick_unique: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hnps_pkg::ST_PICK |-> $onehot(match_vec))
    else $error("rank pick did not match exactly one cell");
  a_rot_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hnps_pkg::ST_ROT && rot_r != IW'(N - 1) |=> state_r == hnps_pkg::ST_ROT)
    else $error("rotation left early");
`endif

endmodule

>>> hw/rtl/hnps_cell.sv
// ----------------------------------------------------------------------------
// hnps_cell
// One table entry of the selector chain: holds a node record, filters it for
// a pass and counts its rank while the chain rotates past the head.
// ----------------------------------------------------------------------------
module hnps_cell (
  input  logic               clk,
  input  hnps_pkg::cell_ctl_t ctl,
  input  logic               pos_valid,
  input  hnps_pkg::ent_t     prev,
  input  hnps_pkg::ent_t     head,
  output hnps_pkg::ent_t     ent
);

  hnps_pkg::ent_t ent_r;
  hnps_pkg::ent_t ent_nxt;
  logic           ok;
  logic           pref;
  logic           av;

  always_comb begin
    pref    = ctl.has_pref && (ent_r.lidx == ctl.pref_idx);
    ok      = pos_valid && !(ctl.avoid_local && pref) && ent_r.rec.alive &&
              !(ctl.non_gpu && ent_r.rec.has_gpu) && ent_r.rec.feasible;
    av      = pref ? ent_r.rec.available_loose : ent_r.rec.available;
    ent_nxt = ent_r;
    case (ctl.op)
      hnps_pkg::CELL_LOAD: ent_nxt = prev;
      hnps_pkg::CELL_PREP: begin
        ent_nxt.in_a    = ok && av;
        ent_nxt.in_u    = ok && !av;
        ent_nxt.is_pref = pos_valid && pref;
        ent_nxt.member  = 1'b0;
        ent_nxt.rank    = '0;
      end
      hnps_pkg::CELL_SEL: ent_nxt.member = ctl.sel_u ? ent_r.in_u : ent_r.in_a;
      hnps_pkg::CELL_ROT: begin
        // The record arriving from the neighbor is ranked against the head.
        ent_nxt = prev;
        if (head.member && prev.member &&
            (hnps_pkg::key_of(head, ctl.thr) < hnps_pkg::key_of(prev, ctl.thr))) begin
          ent_nxt.rank = prev.rank + 1'b1;
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

>>> tb/tb_hybrid_node_placement_selector.sv
// ----------------------------------------------------------------------------
// tb_hybrid_node_placement_selector
// Drives node record sets and register settings into the selector, predicts
// each placement decision in the testbench and checks every result beat.
// ----------------------------------------------------------------------------
module tb_hybrid_node_placement_selector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [15:0] ident;
    bit          alive, has_gpu, feasible, available, available_loose;
    logic [16:0] util;
    bit          is_local, is_named, needs_gpu;
    logic [15:0] draw;
    bit          last;
  } node_item_t;

  typedef struct {
    bit          found;
    logic [15:0] node;
  } placement_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_node_ident = '0;
  logic in_alive = 1'b0, in_has_gpu = 1'b0, in_feasible = 1'b0;
  logic in_available = 1'b0, in_available_loose = 1'b0;
  logic [16:0] in_utilization = '0;
  logic in_is_local = 1'b0, in_is_named_preferred = 1'b0, in_request_needs_gpu = 1'b0;
  logic [15:0] in_random_draw = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_found;
  logic [15:0] out_chosen_node;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [hnps_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [hnps_pkg::CDAT_W-1:0] cfg_data = '0;

  hybrid_node_placement_selector i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state.
  node_item_t  table_q[$];
  bit          named_ok, local_ok;
  int          named_at, local_at;
  logic [16:0] thr_r;
  logic [6:0]  kabs_r;
  logic [16:0] kfrac_r;
  bit          avoid_gpu_r, avoid_loc_r, req_avail_r;
  placement_t  placements_q[$];

  int  errors = 0;
  longint cycles = 0;
  bit  stall_req = 1'b0;
  bit  stall_seen = 1'b0;
  int  long_stall = 0;
  int  rx_gap = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic logic [16:0] score(input int i);
    return (table_q[i].util < thr_r) ? 17'd0 : table_q[i].util;
  endfunction

  function automatic bit orders_first(input int a, input int b);
    if (score(a) != score(b)) return score(a) < score(b);
    if (table_q[a].ident != table_q[b].ident) return table_q[a].ident < table_q[b].ident;
    return a < b;
  endfunction

  function automatic logic [15:0] rank_pick(input int lst[$], input bit prio, input int pref,
                                            input longint k, input logic [15:0] draw);
    int best, m;
    int sorted[$];
    int j;
    sorted = lst;
    for (int i = 1; i < sorted.size(); i++) begin
      best = sorted[i];
      j = i;
      while (j > 0 && orders_first(best, sorted[j-1])) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = best;
    end
    if (prio && score(pref) <= score(sorted[0])) return table_q[pref].ident;
    m = (k < sorted.size()) ? int'(k) : sorted.size();
    if (m == 0) m = 1;
    return table_q[sorted[draw % m]].ident;
  endfunction

  function automatic bit placement_pass(input bit non_gpu, input bit need_av,
                                        input logic [15:0] draw, output logic [15:0] id);
    int avl[$], unav[$];
    int pref;
    bit has_pref, pref_feas, pref_av, is_pref, av;
    longint k;
    pref = 0;
    has_pref = 0;
    pref_feas = 0;
    pref_av = 0;
    id = '0;
    if (named_ok) begin
      has_pref = 1;
      pref = named_at;
    end else if (local_ok) begin
      has_pref = 1;
      pref = local_at;
    end
    foreach (table_q[i]) begin
      is_pref = has_pref && i == pref;
      if (avoid_loc_r && is_pref) continue;
      if (!table_q[i].alive || (non_gpu && table_q[i].has_gpu) || !table_q[i].feasible)
        continue;
      av = is_pref ? table_q[i].available_loose : table_q[i].available;
      if (is_pref) begin
        pref_feas = 1;
        if (av) pref_av = 1;
      end
      if (av) avl = {avl, i};
      else unav = {unav, i};
    end
    k = (longint'(table_q.size()) * longint'(kfrac_r)) >> 16;
    if (k < kabs_r) k = kabs_r;
    if (avl.size() > 0) begin
      id = rank_pick(avl, !avoid_loc_r && pref_av, pref, k, draw);
      return 1;
    end
    if (unav.size() > 0 && !need_av) begin
      id = rank_pick(unav, !avoid_loc_r && pref_feas, pref, k, draw);
      return 1;
    end
    return 0;
  endfunction

  function automatic void predict_record(input node_item_t it);
    placement_t p;
    logic [15:0] id;
    if (table_q.size() < hnps_pkg::NODES) begin
      if (it.is_named && !named_ok) begin
        named_ok = 1;
        named_at = table_q.size();
      end
      if (it.is_local && !local_ok) begin
        local_ok = 1;
        local_at = table_q.size();
      end
      table_q = {table_q, it};
    end
    if (!it.last) return;
    p.found = 0;
    id = '0;
    if (avoid_gpu_r && !it.needs_gpu) p.found = placement_pass(1, 1, it.draw, id);
    if (!p.found) p.found = placement_pass(0, req_avail_r, it.draw, id);
    p.node = p.found ? id : 16'd0;
    placements_q = {placements_q, p};
    table_q.delete();
    named_ok = 0;
    local_ok = 0;
  endfunction

  // Valid drops only when an idle gap follows.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_record(input node_item_t it);
    in_valid <= 1'b1;
    in_node_ident <= it.ident;
    in_alive <= it.alive;
    in_has_gpu <= it.has_gpu;
    in_feasible <= it.feasible;
    in_available <= it.available;
    in_available_loose <= it.available_loose;
    in_utilization <= it.util;
    in_is_local <= it.is_local;
    in_is_named_preferred <= it.is_named;
    in_request_needs_gpu <= it.needs_gpu;
    in_random_draw <= it.draw;
    in_last <= it.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_record(it);
    if ($urandom_range(0, 2) == 0) idle_gap();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (placements_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [hnps_pkg::CIDX_W-1:0] idx,
                           input logic [hnps_pkg::CDAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      hnps_pkg::REG_SPREAD_THR: thr_r = val;
      hnps_pkg::REG_TOPK_ABS:   kabs_r = val[6:0];
      hnps_pkg::REG_TOPK_FRAC:  kfrac_r = val;
      hnps_pkg::REG_AVOID_GPU:  avoid_gpu_r = val[0];
      hnps_pkg::REG_AVOID_LOC:  avoid_loc_r = val[0];
      hnps_pkg::REG_REQ_AVAIL:  req_avail_r = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [16:0] thr, input logic [6:0] kabs,
                          input logic [16:0] kfrac, input bit ag, input bit al, input bit ra);
    drain();
    write_reg(hnps_pkg::REG_SPREAD_THR, thr);
    write_reg(hnps_pkg::REG_TOPK_ABS, {10'd0, kabs});
    write_reg(hnps_pkg::REG_TOPK_FRAC, kfrac);
    write_reg(hnps_pkg::REG_AVOID_GPU, {16'd0, ag});
    write_reg(hnps_pkg::REG_AVOID_LOC, {16'd0, al});
    write_reg(hnps_pkg::REG_REQ_AVAIL, {16'd0, ra});
    cfg_valid <= 1'b0;
  endtask

  function automatic node_item_t rand_record(input bit last);
    node_item_t it;
    it.ident = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    it.alive = $urandom_range(0, 5) != 0;
    it.has_gpu = $urandom_range(0, 1);
    it.feasible = $urandom_range(0, 5) != 0;
    it.available = $urandom_range(0, 1);
    it.available_loose = $urandom_range(0, 1);
    case ($urandom_range(0, 4))
      0: it.util = 17'd65536;
      1: it.util = 17'd0;
      2: it.util = 17'($urandom_range(0, 131071));
      default: it.util = 17'($urandom_range(0, 65536));
    endcase
    it.is_local = $urandom_range(0, 7) == 0;
    it.is_named = $urandom_range(0, 9) == 0;
    it.needs_gpu = $urandom_range(0, 1);
    it.draw = 16'($urandom);
    it.last = last;
    return it;
  endfunction

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send_record(rand_record(i == n - 1));
  endtask

  task automatic test_directed();
    node_item_t it;
    send_set(1);
    it = rand_record(1);
    it.alive = 0;
    send_record(it);                  // no live node
    it = rand_record(0);
    it.ident = 16'hFFFF;
    it.util = 17'd65536;
    it.is_local = 1;
    it.available_loose = 1;
    it.alive = 1;
    it.feasible = 1;
    send_record(it);
    it.ident = 16'h0000;
    it.util = 17'd0;
    it.is_local = 0;
    it.is_named = 1;
    it.available = 0;
    it.available_loose = 0;
    send_record(it);
    it.ident = 16'h0000;              // equal identifiers, tie by load order
    it.is_named = 0;
    it.available = 1;
    it.draw = 16'hFFFF;
    it.last = 1;
    send_record(it);
    send_set(hnps_pkg::NODES + 3);    // full table drops the tail records
  endtask

  task automatic test_settings();
    set_regs(17'd0, 7'd64, 17'd65536, 1, 0, 1);
    for (int s = 0; s < 6; s++) send_set($urandom_range(1, 8));
    set_regs(17'd65536, 7'd127, 17'd131071, 0, 1, 0);
    for (int s = 0; s < 6; s++) send_set($urandom_range(1, 8));
    set_regs(17'd131071, 7'd0, 17'd0, 1, 1, 1);
    for (int s = 0; s < 6; s++) send_set($urandom_range(1, 8));
  endtask

  task automatic test_back_pressure();
    set_regs(17'd32768, 7'd2, 17'd13107, 0, 0, 0);
    stall_req = 1'b1;
    for (int s = 0; s < 10; s++) send_set($urandom_range(1, 3));
  endtask

  task automatic test_random();
    int sent;
    int n;
    sent = 0;
    while (sent < 1780) begin
      if ($urandom_range(0, 149) == 0)
        set_regs(17'($urandom_range(0, 65536)), 7'($urandom_range(0, 127)),
                 17'($urandom_range(0, 131071)), $urandom_range(0, 1),
                 $urandom_range(0, 1), $urandom_range(0, 1));
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 66) : $urandom_range(1, 10);
      send_set(n);
      sent += n;
    end
  endtask

  // Receiver: short random stalls, a few long gaps, and one long hold-off.
  always @(posedge clk) begin
    if (stall_req && !stall_seen) begin
      stall_seen <= 1'b1;
      long_stall <= 400;
      out_ready <= 1'b0;
    end else if (long_stall > 0) begin
      long_stall <= long_stall - 1;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 199) == 0) begin
      rx_gap <= $urandom_range(10, 40);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 30) != 0);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    placement_t exp_p;
    if (rst_n && out_valid && out_ready) begin
      if (placements_q.size() == 0) report("result beat with nothing expected");
      else begin
        exp_p = placements_q.pop_front();
        if (out_found !== exp_p.found)
          report($sformatf("found %0b, expected %0b", out_found, exp_p.found));
        if (out_chosen_node !== exp_p.node)
          report($sformatf("node %0d, expected %0d", out_chosen_node, exp_p.node));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    thr_r = 17'd32768;
    kabs_r = 7'd1;
    kfrac_r = 17'd13107;
    avoid_gpu_r = 0;
    avoid_loc_r = 0;
    req_avail_r = 0;
    named_ok = 0;
    local_ok = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings();
    test_back_pressure();
    test_random();
    drain();
    if (errors == 0 && placements_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/hnps_pkg.sv
hw/rtl/hnps_cell.sv
hw/rtl/hybrid_node_placement_selector.sv
tb/tb_hybrid_node_placement_selector.sv
